// ===== hw/rtl/cseq_pkg.sv =====
`timescale 1ns / 1ps
// cseq_pkg: opcodes, status codes, sequencer states and fixed field widths
// shared by the cursor sequence store and its checker. No dependencies.
package cseq_pkg;

    localparam int OP_W     = 3;
    localparam int WORD_W   = 64;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 7;

    typedef enum logic [OP_W-1:0] {
        OP_START   = 3'd0,
        OP_ADVANCE = 3'd1,
        OP_INSERT  = 3'd2,
        OP_ATTACH  = 3'd3,
        OP_REMOVE  = 3'd4,
        OP_QUERY   = 3'd5
    } opcode_t;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOCUR = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_DRAIN,
        S_PLACE,
        S_FETCH,
        S_CAPTURE
    } state_t;

endpackage

// ===== hw/rtl/cseq_ram.sv =====
`timescale 1ns / 1ps
// cseq_ram: one-write, one-read synchronous RAM with registered read data.
// Uses nothing from cseq_pkg beyond its caller's widths.
module cseq_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 64
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/cursor_sequence_store.sv =====
`timescale 1ns / 1ps
// cursor_sequence_store: bounded ordered list of 64-bit words with a cursor.
// Depends on cseq_pkg and cseq_ram.
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  input   | s_valid s_ready s_opcode s_entry_value         | in
//  result  | m_valid m_ready m_status m_entry_count         | out
//          | m_has_current m_cursor_position m_current_value|
//
// Steps from the accepted request to m_valid: start, advance, query and refused
// requests fetch and capture. Insert and attach place the new word before fetch,
// after shift and drain steps when entries move; remove shifts and drains when
// entries move. One entry moves per cycle through the single RAM read and write
// port. s_ready rises with m_valid, at the edge that registers the result.
// Reset: aresetn (synchronous, active low) empties the list and parks the cursor
// at 0; the RAM keeps no reset and is never read where it was not written.
// Stalls: a new word is taken while a finished result waits in the output
// register; the sequencer holds in its capture step until that register frees.
module cursor_sequence_store #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [cseq_pkg::OP_W-1:0]      s_opcode,
    input  logic [cseq_pkg::WORD_W-1:0]    s_entry_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [cseq_pkg::STATUS_W-1:0]  m_status,
    output logic [cseq_pkg::POS_W-1:0]     m_entry_count,
    output logic                           m_has_current,
    output logic [cseq_pkg::POS_W-1:0]     m_cursor_position,
    output logic [cseq_pkg::WORD_W-1:0]    m_current_value
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int XW = (CW > cseq_pkg::POS_W) ? CW : cseq_pkg::POS_W;
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_ENTRIES);

    // control state
    cseq_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] cursor_reg, cursor_next;
    logic          up_reg, up_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] last_reg, last_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic          m_valid_reg, m_valid_next;

    // payload
    logic [cseq_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [AW-1:0]                 pos_reg, pos_next;
    logic [cseq_pkg::WORD_W-1:0]   word_reg, word_next;
    logic [cseq_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [CW-1:0]                 out_count_reg, out_count_next;
    logic [CW-1:0]                 out_cursor_reg, out_cursor_next;
    logic                          out_has_reg, out_has_next;
    logic [cseq_pkg::WORD_W-1:0]   out_value_reg, out_value_next;

    // RAM port
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [cseq_pkg::WORD_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [cseq_pkg::WORD_W-1:0] ram_rdata;

    // request decode
    logic                          accept;
    logic                          has_cur;
    logic                          out_free;
    logic                          dec_shift;
    logic                          dec_place;
    logic                          dec_up;
    logic [cseq_pkg::STATUS_W-1:0] dec_status;
    logic [CW-1:0]                 dec_count;
    logic [CW-1:0]                 dec_cursor;
    logic [CW-1:0]                 dec_pos;
    logic [CW-1:0]                 dec_first;
    logic [CW-1:0]                 dec_last;
    logic [CW-1:0]                 cur_plus;
    logic [XW-1:0]                 count_wide;
    logic [XW-1:0]                 cursor_wide;

    assign accept   = s_valid && s_ready;
    assign has_cur  = cursor_reg < count_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign cur_plus = cursor_reg + CW'(1);

    // Work out the new count and cursor, and which entries must move.
    always_comb begin
        dec_shift  = 1'b0;
        dec_place  = 1'b0;
        dec_up     = 1'b0;
        dec_status = cseq_pkg::STAT_OK;
        dec_count  = count_reg;
        dec_cursor = cursor_reg;
        dec_pos    = '0;
        dec_first  = '0;
        dec_last   = '0;
        case (s_opcode)
            cseq_pkg::OP_START: begin
                dec_cursor = '0;
            end
            cseq_pkg::OP_ADVANCE: begin
                if (has_cur) begin
                    dec_cursor = cur_plus;
                end else begin
                    dec_status = cseq_pkg::STAT_NOCUR;
                end
            end
            cseq_pkg::OP_INSERT, cseq_pkg::OP_ATTACH: begin
                if (count_reg >= MAX_COUNT) begin
                    dec_status = cseq_pkg::STAT_FULL;
                end else begin
                    if (s_opcode == cseq_pkg::OP_INSERT) begin
                        dec_pos = has_cur ? cursor_reg : '0;
                    end else begin
                        dec_pos = has_cur ? cur_plus : count_reg;
                    end
                    dec_up     = 1'b1;
                    dec_place  = 1'b1;
                    dec_shift  = dec_pos < count_reg;
                    dec_first  = count_reg - CW'(1);
                    dec_last   = dec_pos;
                    dec_count  = count_reg + CW'(1);
                    dec_cursor = dec_pos;
                end
            end
            cseq_pkg::OP_REMOVE: begin
                if (has_cur) begin
                    dec_shift = cur_plus < count_reg;
                    dec_first = cur_plus;
                    dec_last  = count_reg - CW'(1);
                    dec_count = count_reg - CW'(1);
                end else begin
                    dec_status = cseq_pkg::STAT_NOCUR;
                end
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cseq_pkg::S_IDLE: begin
                if (accept) begin
                    if (dec_shift) begin
                        state_next = cseq_pkg::S_SHIFT;
                    end else if (dec_place) begin
                        state_next = cseq_pkg::S_PLACE;
                    end else begin
                        state_next = cseq_pkg::S_FETCH;
                    end
                end
            end
            cseq_pkg::S_SHIFT: begin
                if (idx_reg == last_reg) begin
                    state_next = cseq_pkg::S_DRAIN;
                end
            end
            cseq_pkg::S_DRAIN: begin
                state_next = up_reg ? cseq_pkg::S_PLACE : cseq_pkg::S_FETCH;
            end
            cseq_pkg::S_PLACE: begin
                state_next = cseq_pkg::S_FETCH;
            end
            cseq_pkg::S_FETCH: begin
                state_next = cseq_pkg::S_CAPTURE;
            end
            cseq_pkg::S_CAPTURE: begin
                if (out_free) begin
                    state_next = cseq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = cseq_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and RAM control
    always_comb begin
        s_ready         = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = pend_addr_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = idx_reg;
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        up_next         = up_reg;
        idx_next        = idx_reg;
        last_next       = last_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        status_next     = status_reg;
        pos_next        = pos_reg;
        word_next       = word_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_cursor_next = out_cursor_reg;
        out_has_next    = out_has_reg;
        out_value_next  = out_value_reg;
        unique case (state_reg)
            cseq_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    count_next  = dec_count;
                    cursor_next = dec_cursor;
                    status_next = dec_status;
                    up_next     = dec_up;
                    idx_next    = AW'(dec_first);
                    last_next   = AW'(dec_last);
                    pos_next    = AW'(dec_pos);
                    word_next   = s_entry_value;
                end
            end
            cseq_pkg::S_SHIFT: begin
                // write back the word read last cycle, read the next one
                ram_we          = pend_valid_reg;
                ram_re          = 1'b1;
                pend_valid_next = 1'b1;
                pend_addr_next  = up_reg ? (idx_reg + AW'(1)) : (idx_reg - AW'(1));
                idx_next        = up_reg ? (idx_reg - AW'(1)) : (idx_reg + AW'(1));
            end
            cseq_pkg::S_DRAIN: begin
                ram_we = 1'b1;
            end
            cseq_pkg::S_PLACE: begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg;
                ram_wdata = word_reg;
            end
            cseq_pkg::S_FETCH: begin
                ram_re    = has_cur;
                ram_raddr = AW'(cursor_reg);
            end
            cseq_pkg::S_CAPTURE: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    out_status_next = status_reg;
                    out_count_next  = count_reg;
                    out_cursor_next = cursor_reg;
                    out_has_next    = has_cur;
                    out_value_next  = has_cur ? ram_rdata : '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= cseq_pkg::S_IDLE;
            count_reg      <= '0;
            cursor_reg     <= '0;
            up_reg         <= 1'b0;
            idx_reg        <= '0;
            last_reg       <= '0;
            pend_valid_reg <= 1'b0;
            pend_addr_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            cursor_reg     <= cursor_next;
            up_reg         <= up_next;
            idx_reg        <= idx_next;
            last_reg       <= last_next;
            pend_valid_reg <= pend_valid_next;
            pend_addr_reg  <= pend_addr_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg     <= status_next;
        pos_reg        <= pos_next;
        word_reg       <= word_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_cursor_reg <= out_cursor_next;
        out_has_reg    <= out_has_next;
        out_value_reg  <= out_value_next;
    end

    cseq_ram #(
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (AW),
        .DATA_W (cseq_pkg::WORD_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // report count and cursor in the 7-bit result fields, dropping upper bits
    assign count_wide  = XW'(out_count_reg);
    assign cursor_wide = XW'(out_cursor_reg);

    assign m_valid           = m_valid_reg;
    assign m_status          = out_status_reg;
    assign m_entry_count     = count_wide[cseq_pkg::POS_W-1:0];
    assign m_has_current     = out_has_reg;
    assign m_cursor_position = cursor_wide[cseq_pkg::POS_W-1:0];
    assign m_current_value   = out_value_reg;

endmodule

// ===== hw/rtl/cseq_checker.sv =====
`timescale 1ns / 1ps
// cseq_checker: port-level assertions for cursor_sequence_store, and the bind
// that attaches them. Depends on cseq_pkg.
module cseq_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic [cseq_pkg::OP_W-1:0]      s_opcode,
    input logic [cseq_pkg::WORD_W-1:0]    s_entry_value,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [cseq_pkg::STATUS_W-1:0]  m_status,
    input logic [cseq_pkg::POS_W-1:0]     m_entry_count,
    input logic                           m_has_current,
    input logic [cseq_pkg::POS_W-1:0]     m_cursor_position,
    input logic [cseq_pkg::WORD_W-1:0]    m_current_value
);

    // an offered input word holds until taken
    a_input_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_opcode) && $stable(s_entry_value))
        else $error("input word changed or dropped while waiting");

    // a result word holds until taken
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_current_value))
        else $error("result word changed or dropped while stalled");

    // one word in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a word is still in work");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == cseq_pkg::STAT_OK || m_status == cseq_pkg::STAT_FULL
                     || m_status == cseq_pkg::STAT_NOCUR))
        else $error("undefined status code");

    // without a current entry the cursor sits at the end and the word reads zero
    a_no_current: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_current |->
            m_cursor_position == m_entry_count && m_current_value == '0)
        else $error("cursor or word inconsistent without a current entry");

endmodule

bind cursor_sequence_store cseq_checker u_cseq_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .s_opcode          (s_opcode),
    .s_entry_value     (s_entry_value),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_status          (m_status),
    .m_entry_count     (m_entry_count),
    .m_has_current     (m_has_current),
    .m_cursor_position (m_cursor_position),
    .m_current_value   (m_current_value)
);
